// ----- sv/qwt_pkg.sv -----
// shared types, constants and byte decoders for the quoted word tokenizer
// no dependencies; imported by every module of the block
package qwt_pkg;

    localparam int MAX_TOKENS = 128;
    localparam int TOK_W      = 8;
    localparam int IDX_W      = 7;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        KIND_OPEN = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_DONE = 2'd2
    } rkind_t;

    // all results caused by one input byte
    typedef struct packed {
        logic              has_open;
        logic              has_byte;
        logic              has_done;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        data;
        logic [TOK_W-1:0]  count;
    } bundle_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] decode_slash(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'd10;  // n
            8'h74:   r = 8'd9;   // t
            8'h72:   r = 8'd13;  // r
            8'h66:   r = 8'd12;  // f
            8'h62:   r = 8'd8;   // b
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] decode_caret(input logic [7:0] c);
        logic [7:0] r;
        if (c == CH_QMARK)
            r = CH_DEL;
        else if (c >= 8'h41 && c <= 8'h5A)
            r = c - 8'h40;
        else if (c >= 8'h61 && c <= 8'h7A)
            r = c - 8'h60;
        else
            r = c;
        return r;
    endfunction

endpackage

// ----- sv/quoted_word_tokenizer.sv -----
// a byte accepted by the front end is written into the bundle queue; its first result word
//   is then loaded from the queue head into the registered outputs
// throughput: one byte per cycle while the bundle queue has room; results leave at
//   one word per cycle while res_ready is high, each result of a byte in its own word
// reset (rst_n, async, active low) empties the queue, drops any held word and returns
//   the scanner to outside a word with zero tokens seen
module quoted_word_tokenizer
    import qwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       ch,
    input  logic             last,
    input  logic             byte_valid,
    output logic             byte_ready,
    output logic [1:0]       rkind,
    output logic [7:0]       data,
    output logic [IDX_W-1:0] token_index,
    output logic [TOK_W-1:0] token_count,
    output logic             final_res,
    output logic             res_valid,
    input  logic             res_ready
);

    // front end to queue
    logic    push;
    bundle_t push_data;
    logic    full;

    // queue to result sequencer
    bundle_t head;
    logic    empty;
    logic    pop;

    // byte classification and word/quote/escape tracking; one byte per cycle unless full
    qwt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .last       (last),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .full       (full),
        .push       (push),
        .push_data  (push_data)
    );

    // decouples the byte side from the result side
    qwt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    // splits each bundle into open, byte and done words, in that order
    qwt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .rkind       (rkind),
        .data        (data),
        .token_index (token_index),
        .token_count (token_count),
        .final_res   (final_res)
    );

endmodule

// ----- sv/qwt_front.sv -----
// front end: accepts line bytes, tracks word/quote/escape state, builds result bundles
// depends on qwt_pkg
module qwt_front
    import qwt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    ch,
    input  logic          last,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  logic          full,
    output logic          push,
    output bundle_t       push_data
);

    typedef enum logic [2:0] {
        MODE_OUTSIDE = 3'd0,
        MODE_BARE    = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_SKIP    = 3'd3,
        MODE_IGNORE  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SLASH = 2'd1,
        ESC_CARET = 2'd2
    } esc_t;

    mode_t            mode_reg, mode_next;
    esc_t             esc_reg, esc_next;
    logic             quote_reg, quote_next;
    logic [TOK_W-1:0] tokens_reg, tokens_next;
    logic [TOK_W-1:0] cur;
    logic [7:0]       close_ch;
    logic             accept;
    bundle_t          b;

    assign byte_ready = !full;
    assign accept     = byte_valid && !full;
    assign cur        = tokens_reg - 1'b1;
    assign close_ch   = quote_reg ? CH_SQUOTE : CH_DQUOTE;

    always_comb
    begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        quote_next  = quote_reg;
        tokens_next = tokens_reg;
        b           = '0;
        unique case (mode_reg)
            MODE_OUTSIDE:
            begin
                if (!is_blank(ch))
                begin
                    if (tokens_reg >= TOK_W'(MAX_TOKENS))
                    begin
                        mode_next = MODE_IGNORE;
                    end
                    else
                    begin
                        b.has_open = 1'b1;
                        b.idx      = tokens_reg[IDX_W-1:0];
                        if (ch == CH_DQUOTE || ch == CH_SQUOTE)
                        begin
                            quote_next = (ch == CH_SQUOTE);
                            esc_next   = ESC_NONE;
                            mode_next  = MODE_QUOTED;
                        end
                        else
                        begin
                            b.has_byte = 1'b1;
                            b.data     = ch;
                            mode_next  = MODE_BARE;
                        end
                        tokens_next = tokens_reg + 1'b1;
                    end
                end
            end
            MODE_BARE:
            begin
                if (is_blank(ch))
                    mode_next = MODE_OUTSIDE;
                else
                begin
                    b.has_byte = 1'b1;
                    b.data     = ch;
                    b.idx      = cur[IDX_W-1:0];
                end
            end
            MODE_QUOTED:
            begin
                b.idx = cur[IDX_W-1:0];
                if (esc_reg == ESC_SLASH)
                begin
                    b.has_byte = 1'b1;
                    b.data     = decode_slash(ch);
                    esc_next   = ESC_NONE;
                end
                else if (esc_reg == ESC_CARET)
                begin
                    b.has_byte = 1'b1;
                    b.data     = decode_caret(ch);
                    esc_next   = ESC_NONE;
                end
                else if (ch == close_ch)
                    mode_next = MODE_SKIP;
                else if (ch == CH_BSLASH)
                    esc_next = ESC_SLASH;
                else if (ch == CH_CARET)
                    esc_next = ESC_CARET;
                else
                begin
                    b.has_byte = 1'b1;
                    b.data     = ch;
                end
            end
            MODE_SKIP:
                mode_next = MODE_OUTSIDE;
            MODE_IGNORE:
                mode_next = MODE_IGNORE;
            default:
                mode_next = MODE_OUTSIDE;
        endcase

        // end of line: report the count and start afresh
        if (last)
        begin
            b.has_done  = 1'b1;
            b.count     = tokens_next;
            mode_next   = MODE_OUTSIDE;
            esc_next    = ESC_NONE;
            quote_next  = 1'b0;
            tokens_next = '0;
        end
    end

    assign push      = accept && (b.has_open || b.has_byte || b.has_done);
    assign push_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OUTSIDE;
            esc_reg    <= ESC_NONE;
            quote_reg  <= 1'b0;
            tokens_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            quote_reg  <= quote_next;
            tokens_reg <= tokens_next;
        end
    end

endmodule

// ----- sv/qwt_fifo.sv -----
// short bundle queue between front end and result sequencer
// depends on qwt_pkg
module qwt_fifo
    import qwt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    bundle_t        mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// ----- sv/qwt_back.sv -----
// result sequencer: walks each queued bundle and issues one result word per cycle while res_ready is high
// depends on qwt_pkg
module qwt_back
    import qwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bundle_t          head,
    input  logic             empty,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [1:0]       rkind,
    output logic [7:0]       data,
    output logic [IDX_W-1:0] token_index,
    output logic [TOK_W-1:0] token_count,
    output logic             final_res
);

    logic             res_valid_reg, res_valid_next;
    logic             sent_open_reg, sent_open_next;
    logic             sent_byte_reg, sent_byte_next;
    rkind_t           rkind_reg, rkind_next;
    logic [7:0]       data_reg, data_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [TOK_W-1:0] count_reg, count_next;
    logic             final_reg, final_next;
    logic             load;
    logic             rem_open;
    logic             rem_byte;
    logic             last_item;

    assign load     = !empty && (!res_valid_reg || res_ready);
    assign rem_open = head.has_open && !sent_open_reg;
    assign rem_byte = head.has_byte && !sent_byte_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        sent_open_next = sent_open_reg;
        sent_byte_next = sent_byte_reg;
        rkind_next     = rkind_reg;
        data_next      = data_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        final_next     = final_reg;
        last_item      = 1'b0;
        if (load)
        begin
            res_valid_next = 1'b1;
            data_next      = '0;
            idx_next       = '0;
            count_next     = '0;
            final_next     = 1'b0;
            if (rem_open)
            begin
                rkind_next     = KIND_OPEN;
                idx_next       = head.idx;
                last_item      = !head.has_byte && !head.has_done;
                sent_open_next = 1'b1;
            end
            else if (rem_byte)
            begin
                rkind_next     = KIND_BYTE;
                data_next      = head.data;
                idx_next       = head.idx;
                last_item      = !head.has_done;
                sent_byte_next = 1'b1;
            end
            else
            begin
                rkind_next = KIND_DONE;
                count_next = head.count;
                final_next = 1'b1;
                last_item  = 1'b1;
            end
            if (last_item)
            begin
                sent_open_next = 1'b0;
                sent_byte_next = 1'b0;
            end
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign pop = load && last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sent_open_reg <= 1'b0;
            sent_byte_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            sent_open_reg <= sent_open_next;
            sent_byte_reg <= sent_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rkind_reg <= rkind_next;
        data_reg  <= data_next;
        idx_reg   <= idx_next;
        count_reg <= count_next;
        final_reg <= final_next;
    end

    assign res_valid   = res_valid_reg;
    assign rkind       = rkind_reg;
    assign data        = data_reg;
    assign token_index = idx_reg;
    assign token_count = count_reg;
    assign final_res   = final_reg;

    a_final_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && final_reg) |-> (rkind_reg == KIND_DONE))
        else $error("final word is not a line-finished word");

endmodule
